FILE: rtl/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Types, sizes and helpers for the preemption-threshold scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int TASKS   = 16;
  localparam int POOL    = 32;
  localparam int TIDX_W  = $clog2(TASKS);
  localparam int PIDX_W  = $clog2(POOL);
  localparam int CIDX_W  = 8;

  localparam logic OP_RELEASE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic [CIDX_W-1:0] REG_WINDOW_START = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_WINDOW_END   = CIDX_W'(1);

  typedef struct packed {
    logic        op;
    logic [3:0]  task_id;
    logic [15:0] exec_time;
    logic [7:0]  priority_req;
    logic [7:0]  threshold;
    logic        batch_end;
  } cmd_t;

  typedef struct packed {
    logic        running_valid;
    logic [3:0]  running_task;
    logic        completed;
    logic [3:0]  completed_task;
    logic [31:0] resp_time;
    logic [31:0] best_time;
    logic [31:0] worst_time;
    logic        dropped;
  } result_t;

  // One ready-pool slot; the valid bit lives in flip-flops outside the memory.
  typedef struct packed {
    logic        preempted;
    logic [3:0]  task_id;
    logic [7:0]  prio;
    logic [7:0]  thr;
    logic [15:0] left;
    logic [31:0] arrival;
    logic [31:0] seq;
  } entry_t;

  typedef struct packed {
    logic [31:0] best;
    logic [31:0] worst;
  } stat_t;

  // Outcome of a pool scan.
  typedef struct packed {
    logic              found;
    logic [PIDX_W-1:0] idx;
  } pick_t;

  // True when job a outranks job b: priority, then lower task, then older.
  function automatic logic beats(input logic [7:0] pa, input logic [3:0] ta,
                                 input logic [31:0] sa, input logic [7:0] pb,
                                 input logic [3:0] tb, input logic [31:0] sb);
    logic [31:0] d;
    d = sa - sb;
    if (pa != pb) return pa > pb;
    if (ta != tb) return ta < tb;
    return d[31];
  endfunction

endpackage

FILE: rtl/pts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/pts_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pick
// Tracks the best fresh and the best preempted job while the pool streams by.
// ----------------------------------------------------------------------------
module pts_pick
  import pts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              in_valid,
  input  logic [PIDX_W-1:0] in_idx,
  input  entry_t            in_entry,
  output pick_t             pick
);

  logic              f_v, p_v;
  logic [PIDX_W-1:0] f_idx, p_idx;
  logic [7:0]        f_prio, p_prio;
  logic [3:0]        f_task, p_task;
  logic [31:0]       f_seq, p_seq;
  logic              win_f, win_p;

  assign win_f = !f_v || beats(in_entry.prio, in_entry.task_id, in_entry.seq,
                               f_prio, f_task, f_seq);
  assign win_p = !p_v || beats(in_entry.prio, in_entry.task_id, in_entry.seq,
                               p_prio, p_task, p_seq);

  // Running best of each class.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      f_v <= 1'b0;
      p_v <= 1'b0;
    end else if (in_valid) begin
      if (in_entry.preempted && win_p) begin
        p_v    <= 1'b1;
        p_idx  <= in_idx;
        p_prio <= in_entry.prio;
        p_task <= in_entry.task_id;
        p_seq  <= in_entry.seq;
      end
      if (!in_entry.preempted && win_f) begin
        f_v    <= 1'b1;
        f_idx  <= in_idx;
        f_prio <= in_entry.prio;
        f_task <= in_entry.task_id;
        f_seq  <= in_entry.seq;
      end
    end
  end

  // A preempted job wins ties against a fresh one.
  always_comb begin
    pick.found = f_v || p_v;
    if (p_v && (!f_v || p_prio >= f_prio)) begin
      pick.idx = p_idx;
    end else begin
      pick.idx = f_idx;
    end
  end

endmodule

FILE: rtl/preemption_threshold_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemption_threshold_scheduler_unit
// Fixed-priority scheduler with preemption thresholds, pool kept in RAM.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  cmd       start & !busy             cmd (cmd_t)
//  result    done, one cycle           result (result_t)
//  config    cfg_valid & cfg_ready     cfg_index, cfg_data
//
// A release without dispatch goes only through S_DONE; a dispatch adds S_SCAN
// (one pool RAM read per slot), S_CREAD and S_CLOAD (candidate read), a tick
// adds S_TICK, a completion S_SREAD and S_SUPD for the statistics RAM.
// Reset is synchronous; pool valid bits and statistics valid bits clear at
// once, no clearing pass. The receiver cannot stall; done lasts one cycle.
// ----------------------------------------------------------------------------
module preemption_threshold_scheduler_unit
  import pts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cmd_t              cmd,
  output logic              done,
  output result_t           result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [31:0]       cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_CREAD, S_CLOAD, S_TICK, S_SREAD, S_SUPD, S_DONE
  } state_t;

  state_t            state;
  cmd_t              cmd_r;
  logic [31:0]       window_start, window_end;
  logic [31:0]       time_now, next_seq;
  logic              run_valid;
  logic [3:0]        run_task;
  logic [7:0]        run_prio;
  logic [15:0]       run_left;
  logic [31:0]       run_arrival, run_seq;
  logic [POOL-1:0]   pool_valid;
  logic [TASKS-1:0]  stat_valid;
  logic [PIDX_W:0]   cnt;
  logic              sc_v;
  logic [PIDX_W-1:0] sc_idx;
  logic              cmpl, drop;
  logic [3:0]        ctask;
  logic [31:0]       resp, bt, wt;

  logic              p_we;
  logic [PIDX_W-1:0] p_waddr, p_raddr;
  entry_t            p_wdata, p_rdata;
  logic              s_we;
  logic [TIDX_W-1:0] s_addr;
  stat_t             s_wdata, s_rdata, s_old;
  pick_t             pick;
  logic              full;
  logic [PIDX_W-1:0] free_idx;
  logic              accept, in_win;
  logic [31:0]       t_next;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign full      = &pool_valid;
  assign t_next    = time_now + 32'd1;

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int i = POOL - 1; i >= 0; i--) begin
      if (!pool_valid[i]) free_idx = PIDX_W'(i);
    end
  end

  // Pool RAM port control.
  always_comb begin
    p_we    = 1'b0;
    p_waddr = free_idx;
    p_wdata = '{1'b0, cmd.task_id, cmd.priority_req, cmd.threshold,
                cmd.exec_time, time_now, next_seq};
    p_raddr = cnt[PIDX_W-1:0];
    if (state == S_IDLE) begin
      p_we = accept && cmd.op == OP_RELEASE && !full;
    end
    if (state == S_CREAD || state == S_CLOAD) begin
      p_raddr = pick.idx;
    end
    if (state == S_CLOAD && pick.found && run_valid && p_rdata.prio > run_prio) begin
      p_we    = 1'b1;
      p_waddr = pick.idx;
      p_wdata = '{1'b1, run_task, run_prio, run_prio, run_left, run_arrival, run_seq};
    end
  end

  pts_ram #(.WIDTH($bits(entry_t)), .DEPTH(POOL)) u_pool (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  pts_pick u_pick (
    .clk(clk), .rst(rst), .clear(state == S_IDLE),
    .in_valid(sc_v && pool_valid[sc_idx]), .in_idx(sc_idx),
    .in_entry(p_rdata), .pick(pick)
  );

  // Statistics RAM: read, update within the window, write back.
  assign s_addr  = TIDX_W'(ctask);
  assign s_old   = stat_valid[s_addr] ? s_rdata : stat_t'{32'hFFFF_FFFF, 32'd0};
  assign in_win  = (time_now > window_start) && (time_now <= window_end);
  always_comb begin
    s_wdata = s_old;
    if (in_win) begin
      if (resp > s_old.worst) s_wdata.worst = resp;
      if (resp < s_old.best)  s_wdata.best  = resp;
    end
  end
  assign s_we = (state == S_SUPD);

  pts_ram #(.WIDTH($bits(stat_t)), .DEPTH(TASKS)) u_stat (
    .clk(clk), .we(s_we), .waddr(s_addr), .wdata(s_wdata),
    .raddr(s_addr), .rdata(s_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= 32'd0;
      window_end   <= 32'hFFFF_FFFF;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_WINDOW_START) window_start <= cfg_data;
      if (cfg_index == REG_WINDOW_END)   window_end   <= cfg_data;
    end
  end

  // Sequencer and running-job registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      time_now     <= 32'd0;
      next_seq     <= 32'd0;
      run_valid    <= 1'b0;
      run_task     <= 4'd0;
      run_prio     <= 8'd0;
      run_left     <= 16'd0;
      run_arrival  <= 32'd0;
      run_seq      <= 32'd0;
      pool_valid   <= '0;
      stat_valid   <= '0;
      sc_v         <= 1'b0;
      cnt          <= '0;
    end else begin
      done   <= 1'b0;
      sc_v   <= (state == S_SCAN) && (cnt < (PIDX_W+1)'(POOL));
      sc_idx <= cnt[PIDX_W-1:0];
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            cmd_r <= cmd;
            cmpl  <= 1'b0;
            ctask <= 4'd0;
            resp  <= 32'd0;
            bt    <= 32'd0;
            wt    <= 32'd0;
            drop  <= (cmd.op == OP_RELEASE) && full;
            if (cmd.op == OP_RELEASE) begin
              if (!full) begin
                pool_valid[free_idx] <= 1'b1;
                next_seq             <= next_seq + 32'd1;
              end
              state <= cmd.batch_end ? S_SCAN : S_DONE;
            end else begin
              state <= run_valid ? S_TICK : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cnt == (PIDX_W+1)'(POOL)) begin
            state <= S_CREAD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_CREAD: begin
          state <= S_CLOAD;
        end
        S_CLOAD: begin
          if (pick.found && (!run_valid || p_rdata.prio > run_prio)) begin
            if (!run_valid) pool_valid[pick.idx] <= 1'b0;
            run_valid   <= 1'b1;
            run_task    <= p_rdata.task_id;
            run_prio    <= p_rdata.thr;
            run_left    <= p_rdata.left;
            run_arrival <= p_rdata.arrival;
            run_seq     <= p_rdata.seq;
          end
          state <= (cmd_r.op == OP_TICK) ? S_TICK : S_DONE;
        end
        S_TICK: begin
          time_now <= t_next;
          state    <= S_DONE;
          if (run_valid) begin
            if (run_left <= 16'd1) begin
              run_left  <= 16'd0;
              run_valid <= 1'b0;
              cmpl      <= 1'b1;
              ctask     <= run_task;
              resp      <= t_next - run_arrival;
              state     <= S_SREAD;
            end else begin
              run_left <= run_left - 16'd1;
            end
          end
        end
        S_SREAD: begin
          state <= S_SUPD;
        end
        S_SUPD: begin
          stat_valid[s_addr] <= 1'b1;
          bt    <= s_wdata.best;
          wt    <= s_wdata.worst;
          state <= S_DONE;
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register, loaded as the item finishes.
  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      result.running_valid  <= run_valid;
      result.running_task   <= run_valid ? run_task : 4'd0;
      result.completed      <= cmpl;
      result.completed_task <= ctask;
      result.resp_time      <= resp;
      result.best_time      <= bt;
      result.worst_time     <= wt;
      result.dropped        <= drop;
    end
  end

  // A finished job is no longer running.
  a_cmpl_idle: assert property (@(posedge clk) disable iff (rst)
    done && result.completed |-> !result.running_valid)
    else $error("completion reported with a job still running");

  // Only a release can be dropped.
  a_drop_release: assert property (@(posedge clk) disable iff (rst)
    done && result.dropped |-> cmd_r.op == OP_RELEASE)
    else $error("drop flagged on a tick");

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !done)
    else $error("accepted item did not start");

  // A result is strobed only as the block returns to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(state == S_DONE))
    else $error("result strobe outside finish");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the preemption-threshold scheduler. A scoreboard
// class keeps its own copy of the scheduler state, predicts the result of
// every accepted item and checks each strobed result against the oldest
// prediction. Directed items are followed by random batches of releases and
// ticks, run in phases with different sender gaps and statistics windows.
// ----------------------------------------------------------------------------
module testbench;
  import pts_pkg::*;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  cmd_t              cmd;
  logic              done;
  result_t           result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index;
  logic [31:0]       cfg_data;

  preemption_threshold_scheduler_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    bit          valid;
    bit          preempted;
    logic [3:0]  task_id;
    logic [7:0]  prio;
    logic [7:0]  thr;
    logic [15:0] left;
    logic [31:0] arrival;
    logic [31:0] seq;
  } job_t;

  // Scheduler predictor and the queue of predicted results.
  class sched_scoreboard;
    logic [31:0] win_start, win_end, now, next_seq;
    bit          run_valid;
    job_t        running;
    job_t        pool[POOL];
    logic [31:0] best_resp[TASKS];
    logic [31:0] worst_resp[TASKS];
    result_t     expected_q[$];
    int          errors;

    function new();
      win_start = '0;
      win_end = '1;
      now = '0;
      next_seq = '0;
      run_valid = 0;
      running = '{default: '0};
      foreach (pool[i]) pool[i] = '{default: '0};
      foreach (best_resp[i]) begin
        best_resp[i] = '1;
        worst_resp[i] = '0;
      end
      errors = 0;
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [31:0] val);
      if (idx == REG_WINDOW_START) win_start = val;
      else if (idx == REG_WINDOW_END) win_end = val;
    endfunction

    function bit outranks(job_t a, job_t b);
      logic [31:0] d;
      d = a.seq - b.seq;
      if (a.prio != b.prio) return a.prio > b.prio;
      if (a.task_id != b.task_id) return a.task_id < b.task_id;
      return d[31];
    endfunction

    function int best_slot(bit pre);
      int b;
      b = -1;
      for (int i = 0; i < POOL; i++) begin
        if (!pool[i].valid || pool[i].preempted != pre) continue;
        if (b < 0 || outranks(pool[i], pool[b])) b = i;
      end
      return b;
    endfunction

    function void run_job(job_t j);
      running = j;
      running.prio = j.thr;
      run_valid = 1;
    endfunction

    // Pick the candidate; a preempted job wins ties against a fresh one.
    function void dispatch();
      int   fresh, pre, pick;
      job_t cand;
      fresh = best_slot(0);
      pre = best_slot(1);
      pick = fresh;
      if (pre >= 0 && (fresh < 0 || pool[pre].prio >= pool[fresh].prio)) pick = pre;
      if (pick < 0) return;
      cand = pool[pick];
      if (!run_valid) begin
        pool[pick].valid = 0;
        run_job(cand);
      end else if (cand.prio > running.prio) begin
        pool[pick] = running;
        pool[pick].valid = 1;
        pool[pick].preempted = 1;
        pool[pick].thr = running.prio;
        run_job(cand);
      end
    endfunction

    function void note_cmd(cmd_t c);
      result_t r;
      int      free_slot;
      r = '0;
      if (c.op == OP_RELEASE) begin
        free_slot = -1;
        for (int i = 0; i < POOL; i++) begin
          if (!pool[i].valid) begin
            free_slot = i;
            break;
          end
        end
        if (free_slot < 0) begin
          r.dropped = 1'b1;
        end else begin
          pool[free_slot] = '{1'b1, 1'b0, c.task_id, c.priority_req, c.threshold,
                              c.exec_time, now, next_seq};
          next_seq++;
        end
        if (c.batch_end) dispatch();
      end else begin
        if (!run_valid) dispatch();
        now++;
        if (run_valid) begin
          if (running.left <= 1) begin
            run_valid = 0;
            running.left = '0;
            r.completed = 1'b1;
            r.completed_task = running.task_id;
            r.resp_time = now - running.arrival;
            // Statistics only count inside the configured window.
            if (now > win_start && now <= win_end) begin
              if (r.resp_time > worst_resp[running.task_id])
                worst_resp[running.task_id] = r.resp_time;
              if (r.resp_time < best_resp[running.task_id])
                best_resp[running.task_id] = r.resp_time;
            end
            r.best_time = best_resp[running.task_id];
            r.worst_time = worst_resp[running.task_id];
          end else begin
            running.left--;
          end
        end
      end
      r.running_valid = run_valid;
      r.running_task = run_valid ? running.task_id : 4'd0;
      expected_q.insert(expected_q.size(), r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(result_t got);
      result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(got.running_task), 32'd0);
        return;
      end
      e = expected_q.pop_front();
      if (got.running_valid !== e.running_valid)
        report_mismatch("running_valid", 32'(got.running_valid), 32'(e.running_valid));
      if (got.running_task !== e.running_task)
        report_mismatch("running_task", 32'(got.running_task), 32'(e.running_task));
      if (got.completed !== e.completed)
        report_mismatch("completed", 32'(got.completed), 32'(e.completed));
      if (got.completed_task !== e.completed_task)
        report_mismatch("completed_task", 32'(got.completed_task),
                        32'(e.completed_task));
      if (got.resp_time !== e.resp_time)
        report_mismatch("resp_time", got.resp_time, e.resp_time);
      if (got.best_time !== e.best_time)
        report_mismatch("best_time", got.best_time, e.best_time);
      if (got.worst_time !== e.worst_time)
        report_mismatch("worst_time", got.worst_time, e.worst_time);
      if (got.dropped !== e.dropped)
        report_mismatch("dropped", 32'(got.dropped), 32'(e.dropped));
    endtask
  endclass

  sched_scoreboard sched_sb;
  int              gap_pct;
  int              sent;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Results last one cycle and are taken at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && done) sched_sb.check_result(result);
  end

  // Present one item and hold it until the block takes it.
  task automatic send_item(cmd_t c);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    sched_sb.note_cmd(c);
    sent++;
  endtask

  task automatic release_job(logic [3:0] t, logic [15:0] ex, logic [7:0] p,
                             logic [7:0] th, logic be);
    send_item('{OP_RELEASE, t, ex, p, th, be});
  endtask

  task automatic tick_item();
    cmd_t c;
    c = cmd_t'(38'({$urandom, $urandom}));
    c.op = OP_TICK;
    send_item(c);
  endtask

  // Wait until every predicted result is in and the block is quiet.
  task automatic drain();
    start <= 1'b0;
    while (sched_sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // One register write; the channel is then left idle before the task returns.
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sched_sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Random job content, mostly short so that jobs finish often.
  task automatic random_release(logic be);
    logic [15:0] ex;
    ex = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    release_job(4'($urandom), ex, 8'($urandom), 8'($urandom), be);
  endtask

  task automatic random_phase(int count);
    int target, k;
    target = sent + count;
    while (sent < target) begin
      if ($urandom_range(99) < 85) begin
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) random_release(i == k - 1);
        repeat ($urandom_range(1, 6)) tick_item();
      end else if ($urandom_range(1)) begin
        random_release(1'($urandom));
      end else begin
        tick_item();
      end
    end
  endtask

  initial begin
    sched_sb = new();
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gap_pct = 0;
    sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, zero execution time, ties, thresholds.
    tick_item();
    release_job(4'd15, 16'hFFFF, 8'd0, 8'd0, 1'b0);
    release_job(4'd0, 16'd0, 8'd255, 8'd255, 1'b1);
    tick_item();
    release_job(4'd3, 16'd2, 8'd10, 8'd40, 1'b1);
    release_job(4'd2, 16'd2, 8'd10, 8'd10, 1'b1);
    tick_item();
    release_job(4'd5, 16'd3, 8'd30, 8'd30, 1'b1);
    release_job(4'd6, 16'd1, 8'd60, 8'd60, 1'b1);
    release_job(4'd6, 16'd1, 8'd60, 8'd60, 1'b1);
    repeat (8) tick_item();
    release_job(4'd9, 16'd1, 8'd255, 8'd0, 1'b1);
    repeat (3) tick_item();

    // Fill the pool past its size so releases get dropped, then drain it.
    for (int i = 0; i < POOL + 2; i++) random_release(i == POOL + 1);
    drain();
    write_reg(REG_WINDOW_START, sched_sb.now + 20);
    write_reg(REG_WINDOW_END, sched_sb.now + 400);
    gap_pct = 0;
    random_phase(190);

    drain();
    write_reg(REG_WINDOW_START, 32'hFFFF_FFFF);
    write_reg(REG_WINDOW_END, 32'h0000_0000);
    gap_pct = 51;
    random_phase(190);

    drain();
    write_reg(REG_WINDOW_START, 32'h0000_0000);
    write_reg(REG_WINDOW_END, 32'hFFFF_FFFF);
    gap_pct = 0;
    random_phase(150);

    drain();
    write_reg(REG_WINDOW_START, sched_sb.now);
    write_reg(REG_WINDOW_END, sched_sb.now + 150);
    gap_pct = 7;
    random_phase(150);

    drain();
    if (sched_sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
